>>> rtl/core/icmp_echo_tracker_macros.svh
// assertion macros for the icmp echo tracker
// no dependencies; included by the top level
`ifndef ICMP_ECHO_TRACKER_MACROS_SVH
`define ICMP_ECHO_TRACKER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define IET_ASSERT_IMPL(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("icmp_echo_tracker: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define IET_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("icmp_echo_tracker: next-cycle check failed");

`endif

>>> rtl/core/iet_pkg.sv
// shared types, constants and functions of the icmp echo tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iet_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [7:0] NONE_BYTE  = 8'hFF;
    localparam logic [7:0] ADMIN_CODE = 8'd13;
    localparam logic [7:0] MAX_UNREACH_CODE = 8'd5;

    // icmp message types
    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE_UNREACH    = 8'd3;
    localparam logic [7:0] TYPE_REDIRECT   = 8'd5;
    localparam logic [7:0] TYPE_TIME_EXC   = 8'd11;
    localparam logic [7:0] TYPE_PARAM      = 8'd12;

    // ping status codes
    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_TTL           = 4'd1;
    localparam logic [3:0] ST_PARAM         = 4'd2;
    localparam logic [3:0] ST_REDIRECT      = 4'd3;
    localparam logic [3:0] ST_UNREACH_BASE  = 4'd4;
    localparam logic [3:0] ST_UNREACH_ADMIN = 4'd10;
    localparam logic [3:0] ST_UNKNOWN       = 4'd11;
    localparam logic [3:0] ST_TIMEOUT       = 4'd12;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_MSG   = 2'd1,
        OP_POLL  = 2'd2,
        OP_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        RK_STARTED  = 3'd0,
        RK_FULL     = 3'd1,
        RK_PENDING  = 3'd2,
        RK_FINISHED = 3'd3,
        RK_MATCHED  = 3'd4,
        RK_IGNORED  = 3'd5,
        RK_TICK     = 3'd6
    } result_kind_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_PRD    = 5'b00100,
        S_PCALC  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic poll_rd;
        logic poll_calc;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } dp_status_t;

    function automatic logic msg_accepted(input logic [7:0] t);
        return (t == TYPE_ECHO_REPLY) || (t == TYPE_UNREACH) || (t == TYPE_REDIRECT) ||
               (t == TYPE_TIME_EXC) || (t == TYPE_PARAM);
    endfunction

    function automatic logic [3:0] status_of(input logic [7:0] t, input logic [7:0] c);
        logic [3:0] s;
        s = ST_UNKNOWN;
        if (t == TYPE_ECHO_REPLY)
        begin
            s = ST_OK;
        end
        else if (t == TYPE_TIME_EXC)
        begin
            s = ST_TTL;
        end
        else if (t == TYPE_PARAM)
        begin
            s = ST_PARAM;
        end
        else if (t == TYPE_REDIRECT)
        begin
            s = ST_REDIRECT;
        end
        else if (t == TYPE_UNREACH)
        begin
            if (c <= MAX_UNREACH_CODE)
            begin
                s = ST_UNREACH_BASE + c[3:0];
            end
            else if (c == ADMIN_CODE)
            begin
                s = ST_UNREACH_ADMIN;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/iet_ctrl.sv
// sequencing state machine of the icmp echo tracker
// depends on iet_pkg
`timescale 1ns / 1ps
`default_nettype none

module iet_ctrl
    import iet_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] opcode,
    input  dp_status_t      status,
    output dp_cmd_t         cmd,
    output logic            in_stall
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (opcode_t'(opcode))
                        OP_START: state_next = S_SCAN;
                        OP_MSG:   state_next = S_SCAN;
                        OP_POLL:  state_next = S_PRD;
                        default:  state_next = S_RESULT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_PRD:
            begin
                cmd.poll_rd = 1'b1;
                state_next  = S_PCALC;
            end
            S_PCALC:
            begin
                cmd.poll_calc = 1'b1;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/iet_dp.sv
// datapath of the icmp echo tracker: slot table, clock, scan and output register
// depends on iet_pkg
`timescale 1ns / 1ps
`default_nettype none

module iet_dp
    import iet_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] ping_id,
    input  wire logic [15:0] ping_seq,
    input  wire logic [31:0] wait_limit_ms,
    input  wire logic [7:0]  msg_type,
    input  wire logic [7:0]  msg_code,
    input  wire logic        frame_ok,
    input  wire logic [3:0]  slot_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       result_kind,
    output logic [3:0]       slot_out,
    output logic [3:0]       ping_status,
    output logic [31:0]      rtt_ms,
    output logic [7:0]       reply_type,
    output logic [7:0]       reply_code,
    output logic             success
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RNG_W = (CNT_W > 4) ? CNT_W + 1 : 5;

    // captured item
    opcode_t     op_reg;
    logic [31:0] key_reg;
    logic [31:0] limit_reg;
    logic [7:0]  mtype_reg;
    logic [7:0]  mcode_reg;
    logic        fok_reg;
    logic [3:0]  pidx_reg;
    logic        pidx_ok_reg;

    // slot flags and clock
    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] ans_reg;
    logic [31:0]      now_reg;

    // scan pipeline
    logic [CNT_W-1:0] scan_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;

    // slot storage
    logic [31:0] key_mem   [0:SLOTS-1];
    logic [15:0] ans_mem   [0:SLOTS-1];
    logic [31:0] start_mem [0:SLOTS-1];
    logic [31:0] end_mem   [0:SLOTS-1];
    logic [31:0] limit_mem [0:SLOTS-1];

    logic [31:0] key_rd_reg;
    logic [15:0] ans_rd_reg;
    logic [31:0] start_rd_reg;
    logic [31:0] end_rd_reg;
    logic [31:0] limit_rd_reg;

    logic [31:0] age_reg;
    logic [31:0] rtt_reg;

    // output register
    logic         out_valid_reg;
    result_kind_t kind_reg;
    logic [3:0]   slot_reg;
    logic [3:0]   pstat_reg;
    logic [31:0]  rtt_out_reg;
    logic [7:0]   type_reg;
    logic [7:0]   code_reg;
    logic         success_reg;

    logic [IDX_W-1:0] pidx_a;
    logic [IDX_W-1:0] scan_a;
    logic [IDX_W-1:0] rd_addr;
    logic             scan_left;
    logic             issue;
    logic             rd_en;
    logic             msg_ok;
    logic             hit_now;
    logic             poll_used;
    logic             poll_ans;
    logic             timeout;
    logic [15:0]      ans_wdata;

    result_kind_t res_kind;
    logic [3:0]   res_slot;
    logic [3:0]   res_status;
    logic [31:0]  res_rtt;
    logic [7:0]   res_type;
    logic [7:0]   res_code;
    logic         res_success;
    logic         we_start;
    logic         we_answer;
    logic         clr_slot;
    logic         now_inc;

    assign pidx_a    = IDX_W'(pidx_reg);
    assign scan_a    = scan_reg[IDX_W-1:0];
    assign scan_left = (scan_reg != CNT_W'(SLOTS));
    assign msg_ok    = fok_reg && msg_accepted(mtype_reg);

    // compare stage: free slot for start, used slot with same key for an accepted message
    always_comb
    begin
        hit_now = 1'b0;
        if (cmd.scan_step && cmp_vld_reg)
        begin
            if (op_reg == OP_START)
            begin
                hit_now = !used_reg[cmp_idx_reg];
            end
            else
            begin
                hit_now = msg_ok && used_reg[cmp_idx_reg] && (key_rd_reg == key_reg);
            end
        end
    end

    assign issue   = cmd.scan_step && !hit_reg && !hit_now && scan_left;
    assign rd_en   = cmd.poll_rd || issue;
    assign rd_addr = cmd.poll_rd ? pidx_a : scan_a;

    assign status.scan_end = hit_reg || (!scan_left && !cmp_vld_reg);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign poll_used = pidx_ok_reg && used_reg[pidx_a];
    assign poll_ans  = ans_reg[pidx_a];
    assign timeout   = (age_reg >= limit_rd_reg);
    assign ans_wdata = {mtype_reg, (mtype_reg == TYPE_ECHO_REPLY) ? 8'h00 : mcode_reg};

    // result and table updates of the finishing item
    always_comb
    begin
        res_kind    = RK_IGNORED;
        res_slot    = 4'd0;
        res_status  = ST_OK;
        res_rtt     = 32'd0;
        res_type    = NONE_BYTE;
        res_code    = NONE_BYTE;
        res_success = 1'b0;
        we_start    = 1'b0;
        we_answer   = 1'b0;
        clr_slot    = 1'b0;
        now_inc     = 1'b0;
        case (op_reg)
            OP_START:
            begin
                if (hit_reg)
                begin
                    res_kind = RK_STARTED;
                    res_slot = 4'(hit_idx_reg);
                    we_start = cmd.finish;
                end
                else
                begin
                    res_kind   = RK_FULL;
                    res_status = ST_UNKNOWN;
                end
            end
            OP_MSG:
            begin
                if (hit_reg)
                begin
                    res_kind  = RK_MATCHED;
                    res_slot  = 4'(hit_idx_reg);
                    we_answer = cmd.finish;
                end
            end
            OP_POLL:
            begin
                if (poll_used)
                begin
                    res_slot = pidx_reg;
                    if (poll_ans)
                    begin
                        res_kind    = RK_FINISHED;
                        res_status  = status_of(ans_rd_reg[15:8], ans_rd_reg[7:0]);
                        res_rtt     = rtt_reg;
                        res_type    = ans_rd_reg[15:8];
                        res_code    = ans_rd_reg[7:0];
                        res_success = (ans_rd_reg[15:8] == TYPE_ECHO_REPLY);
                        clr_slot    = cmd.finish;
                    end
                    else if (timeout)
                    begin
                        res_kind   = RK_FINISHED;
                        res_status = ST_TIMEOUT;
                        clr_slot   = cmd.finish;
                    end
                    else
                    begin
                        res_kind = RK_PENDING;
                    end
                end
            end
            default:
            begin
                res_kind = RK_TICK;
                now_inc  = cmd.finish;
            end
        endcase
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg     <= {ping_id, ping_seq};
            limit_reg   <= wait_limit_ms;
            mtype_reg   <= msg_type;
            mcode_reg   <= msg_code;
            fok_reg     <= frame_ok;
            pidx_reg    <= slot_index;
            pidx_ok_reg <= (RNG_W'(slot_index) < RNG_W'(SLOTS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_TICK;
        end
        else if (cmd.load)
        begin
            op_reg <= opcode_t'(opcode);
        end
    end

    // scan counter and compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            cmp_vld_reg <= issue;
            if (issue)
            begin
                scan_reg    <= scan_reg + CNT_W'(1);
                cmp_idx_reg <= scan_a;
            end
            if (hit_now)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // flags and clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            ans_reg  <= '0;
            now_reg  <= 32'd0;
        end
        else
        begin
            if (we_start)
            begin
                used_reg[hit_idx_reg] <= 1'b1;
                ans_reg[hit_idx_reg]  <= 1'b0;
            end
            if (we_answer)
            begin
                ans_reg[hit_idx_reg] <= 1'b1;
            end
            if (clr_slot)
            begin
                used_reg[pidx_a] <= 1'b0;
                ans_reg[pidx_a]  <= 1'b0;
            end
            if (now_inc)
            begin
                now_reg <= now_reg + 32'd1;
            end
        end
    end

    // slot storage writes
    always_ff @(posedge clk)
    begin
        if (we_start)
        begin
            key_mem[hit_idx_reg]   <= key_reg;
            start_mem[hit_idx_reg] <= now_reg;
            limit_mem[hit_idx_reg] <= limit_reg;
        end
        if (we_answer)
        begin
            ans_mem[hit_idx_reg] <= ans_wdata;
            end_mem[hit_idx_reg] <= now_reg;
        end
    end

    // slot storage reads, one address per cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_rd_reg   <= key_mem[rd_addr];
            ans_rd_reg   <= ans_mem[rd_addr];
            start_rd_reg <= start_mem[rd_addr];
            end_rd_reg   <= end_mem[rd_addr];
            limit_rd_reg <= limit_mem[rd_addr];
        end
    end

    // elapsed time and round trip, registered for the timeout check in the result state
    always_ff @(posedge clk)
    begin
        if (cmd.poll_calc)
        begin
            age_reg <= now_reg - start_rd_reg;
            rtt_reg <= (end_rd_reg >= start_rd_reg) ? (end_rd_reg - start_rd_reg) : 32'd0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            kind_reg    <= res_kind;
            slot_reg    <= res_slot;
            pstat_reg   <= res_status;
            rtt_out_reg <= res_rtt;
            type_reg    <= res_type;
            code_reg    <= res_code;
            success_reg <= res_success;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign slot_out    = slot_reg;
    assign ping_status = pstat_reg;
    assign rtt_ms      = rtt_out_reg;
    assign reply_type  = type_reg;
    assign reply_code  = code_reg;
    assign success     = success_reg;

endmodule

`default_nettype wire

>>> rtl/core/icmp_echo_tracker.sv
// start and incoming message: the scan reads one slot per cycle, set by the single read
// port of the slot table, and a hit ends the scan early; a poll reads its slot, then works
// out the age and round trip; a tick goes straight to the result, and every item then waits
// for the output register to be free; one item at a time: the next transfer is taken on
// the cycle after the result is written
// reset: asynchronous, active low; clears all slot flags and the millisecond counter
`timescale 1ns / 1ps
`default_nettype none
`include "icmp_echo_tracker_macros.svh"

module icmp_echo_tracker
    import iet_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] ping_id,
    input  wire logic [15:0] ping_seq,
    input  wire logic [31:0] wait_limit_ms,
    input  wire logic [7:0]  msg_type,
    input  wire logic [7:0]  msg_code,
    input  wire logic        frame_ok,
    input  wire logic [3:0]  slot_index,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       result_kind,
    output logic [3:0]       slot_out,
    output logic [3:0]       ping_status,
    output logic [31:0]      rtt_ms,
    output logic [7:0]       reply_type,
    output logic [7:0]       reply_code,
    output logic             success
);

    // commands from the state machine, status back from the datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: idle, slot scan, poll read and compute, result hand-off
    iet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // slot table, millisecond counter, scan pipeline and result register
    iet_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .ping_id       (ping_id),
        .ping_seq      (ping_seq),
        .wait_limit_ms (wait_limit_ms),
        .msg_type      (msg_type),
        .msg_code      (msg_code),
        .frame_ok      (frame_ok),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .slot_out      (slot_out),
        .ping_status   (ping_status),
        .rtt_ms        (rtt_ms),
        .reply_type    (reply_type),
        .reply_code    (reply_code),
        .success       (success)
    );

    // a transfer in makes the block busy on the next cycle
    `IET_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)
    // a result is only written when the output register can take it
    `IET_ASSERT_IMPL(a_finish_when_free, clk, rst_n, cmd.finish, status.out_free)
    // a finished item shows up at the output on the next cycle
    `IET_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.finish, out_valid)
    // at most one command per cycle
    `IET_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for icmp_echo_tracker: directed, backpressure and random traffic
// checked against an in-bench model of the echo table; depends on iet_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    import iet_pkg::*;

    localparam int TRACKER_SLOTS = SLOTS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 200;
    // scan of every slot plus pipeline stages and the output register
    localparam int SETTLE_CYCLES = 2 * TRACKER_SLOTS + 16;

    // one input transfer
    typedef struct {
        opcode_t     op;
        logic [15:0] id;
        logic [15:0] seq;
        logic [31:0] lim;
        logic [7:0]  mtype;
        logic [7:0]  mcode;
        logic        fok;
        logic [3:0]  idx;
    } ping_item_t;

    // one result transfer
    typedef struct packed {
        result_kind_t kind;
        logic [3:0]   slot;
        logic [3:0]   status;
        logic [31:0]  rtt;
        logic [7:0]   rtype;
        logic [7:0]   rcode;
        logic         ok;
    } echo_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_TICK;
    logic [15:0] ping_id = '0;
    logic [15:0] ping_seq = '0;
    logic [31:0] wait_limit_ms = '0;
    logic [7:0]  msg_type = '0;
    logic [7:0]  msg_code = '0;
    logic        frame_ok = 1'b0;
    logic [3:0]  slot_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  result_kind;
    logic [3:0]  slot_out;
    logic [3:0]  ping_status;
    logic [31:0] rtt_ms;
    logic [7:0]  reply_type;
    logic [7:0]  reply_code;
    logic        success;

    // echo table as the block should hold it
    logic        tbl_used     [TRACKER_SLOTS];
    logic        tbl_answered [TRACKER_SLOTS];
    logic [15:0] tbl_id       [TRACKER_SLOTS];
    logic [15:0] tbl_seq      [TRACKER_SLOTS];
    logic [7:0]  tbl_type     [TRACKER_SLOTS];
    logic [7:0]  tbl_code     [TRACKER_SLOTS];
    logic [31:0] tbl_t0       [TRACKER_SLOTS];
    logic [31:0] tbl_t1       [TRACKER_SLOTS];
    logic [31:0] tbl_limit    [TRACKER_SLOTS];
    logic [31:0] clock_ms = '0;

    echo_result_t echo_results_q[$];
    int           fail_count = 0;
    int           items_sent = 0;
    int           kind_count [7];
    int           cycle_count = 0;
    bit           gaps_on = 1'b1;
    int           rx_hold_req = 0;
    int           rx_left = 0;
    int           rx_gap = 0;

    icmp_echo_tracker #(
        .SLOTS (TRACKER_SLOTS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .ping_id       (ping_id),
        .ping_seq      (ping_seq),
        .wait_limit_ms (wait_limit_ms),
        .msg_type      (msg_type),
        .msg_code      (msg_code),
        .frame_ok      (frame_ok),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .slot_out      (slot_out),
        .ping_status   (ping_status),
        .rtt_ms        (rtt_ms),
        .reply_type    (reply_type),
        .reply_code    (reply_code),
        .success       (success)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        foreach (tbl_used[i])
        begin
            tbl_used[i]     = 1'b0;
            tbl_answered[i] = 1'b0;
        end
        foreach (kind_count[i])
        begin
            kind_count[i] = 0;
        end
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 45);
    endfunction

    // mapping of the stored icmp type and code onto the reported status
    function automatic logic [3:0] expected_status(input logic [7:0] t, input logic [7:0] c);
        case (t)
            TYPE_ECHO_REPLY: return ST_OK;
            TYPE_TIME_EXC:   return ST_TTL;
            TYPE_PARAM:      return ST_PARAM;
            TYPE_REDIRECT:   return ST_REDIRECT;
            TYPE_UNREACH:
            begin
                if (c <= MAX_UNREACH_CODE)
                begin
                    return ST_UNREACH_BASE + c[3:0];
                end
                if (c == ADMIN_CODE)
                begin
                    return ST_UNREACH_ADMIN;
                end
                return ST_UNKNOWN;
            end
            default:         return ST_UNKNOWN;
        endcase
    endfunction

    function automatic logic type_tracked(input logic [7:0] t);
        case (t)
            TYPE_ECHO_REPLY, TYPE_UNREACH, TYPE_REDIRECT, TYPE_TIME_EXC, TYPE_PARAM:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // applies one transfer to the echo table and returns the result it should give
    function automatic echo_result_t echo_table_step(input ping_item_t it);
        echo_result_t r;
        logic         hit;
        logic [31:0]  age;
        r.kind   = RK_IGNORED;
        r.slot   = '0;
        r.status = ST_OK;
        r.rtt    = '0;
        r.rtype  = NONE_BYTE;
        r.rcode  = NONE_BYTE;
        r.ok     = 1'b0;
        hit      = 1'b0;
        case (it.op)
            OP_START:
            begin
                for (int i = 0; i < TRACKER_SLOTS; i++)
                begin
                    if (!hit && !tbl_used[i])
                    begin
                        hit             = 1'b1;
                        tbl_used[i]     = 1'b1;
                        tbl_answered[i] = 1'b0;
                        tbl_id[i]       = it.id;
                        tbl_seq[i]      = it.seq;
                        tbl_type[i]     = NONE_BYTE;
                        tbl_code[i]     = NONE_BYTE;
                        tbl_t0[i]       = clock_ms;
                        tbl_t1[i]       = '0;
                        tbl_limit[i]    = it.lim;
                        r.kind          = RK_STARTED;
                        r.slot          = i[3:0];
                    end
                end
                if (!hit)
                begin
                    r.kind   = RK_FULL;
                    r.status = ST_UNKNOWN;
                end
            end
            OP_MSG:
            begin
                if (it.fok && type_tracked(it.mtype))
                begin
                    for (int i = 0; i < TRACKER_SLOTS; i++)
                    begin
                        if (!hit && tbl_used[i] && tbl_id[i] == it.id && tbl_seq[i] == it.seq)
                        begin
                            // a later answer simply overwrites an earlier one
                            hit             = 1'b1;
                            tbl_answered[i] = 1'b1;
                            tbl_type[i]     = it.mtype;
                            // echo reply keeps code zero whatever the frame said
                            tbl_code[i]     = (it.mtype == TYPE_ECHO_REPLY) ? 8'd0 : it.mcode;
                            tbl_t1[i]       = clock_ms;
                            r.kind          = RK_MATCHED;
                            r.slot          = i[3:0];
                        end
                    end
                end
            end
            OP_POLL:
            begin
                if (it.idx < TRACKER_SLOTS && tbl_used[it.idx])
                begin
                    age = clock_ms - tbl_t0[it.idx];
                    r.slot = it.idx;
                    if (tbl_answered[it.idx])
                    begin
                        // an answer wins over an expired timeout
                        tbl_used[it.idx] = 1'b0;
                        r.kind   = RK_FINISHED;
                        r.status = expected_status(tbl_type[it.idx], tbl_code[it.idx]);
                        r.rtt    = (tbl_t1[it.idx] >= tbl_t0[it.idx]) ?
                                   tbl_t1[it.idx] - tbl_t0[it.idx] : 32'd0;
                        r.rtype  = tbl_type[it.idx];
                        r.rcode  = tbl_code[it.idx];
                        r.ok     = (tbl_type[it.idx] == TYPE_ECHO_REPLY);
                    end
                    else if (age >= tbl_limit[it.idx])
                    begin
                        tbl_used[it.idx] = 1'b0;
                        r.kind   = RK_FINISHED;
                        r.status = ST_TIMEOUT;
                    end
                    else
                    begin
                        r.kind = RK_PENDING;
                    end
                end
            end
            default:
            begin
                clock_ms = clock_ms + 32'd1;
                r.kind   = RK_TICK;
            end
        endcase
        return r;
    endfunction

    // random filler for every field; callers override what the operation uses
    function automatic ping_item_t random_item(input opcode_t op);
        ping_item_t it;
        it.op    = op;
        it.id    = 16'($urandom);
        it.seq   = 16'($urandom);
        it.lim   = $urandom;
        it.mtype = 8'($urandom);
        it.mcode = 8'($urandom);
        it.fok   = 1'($urandom);
        it.idx   = 4'($urandom);
        return it;
    endfunction

    // offers one item, waits for the transfer, records what should come back
    task automatic send_item(input ping_item_t it);
        echo_result_t r;
        int           gap;
        in_valid      <= 1'b1;
        opcode        <= it.op;
        ping_id       <= it.id;
        ping_seq      <= it.seq;
        wait_limit_ms <= it.lim;
        msg_type      <= it.mtype;
        msg_code      <= it.mcode;
        frame_ok      <= it.fok;
        slot_index    <= it.idx;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        r = echo_table_step(it);
        echo_results_q.push_back(r);
        items_sent++;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic start_ping(input logic [15:0] id, input logic [15:0] seq,
                              input logic [31:0] lim);
        ping_item_t it;
        it     = random_item(OP_START);
        it.id  = id;
        it.seq = seq;
        it.lim = lim;
        send_item(it);
    endtask

    task automatic send_msg(input logic [7:0] t, input logic [7:0] c, input logic ok,
                            input logic [15:0] id, input logic [15:0] seq);
        ping_item_t it;
        it       = random_item(OP_MSG);
        it.mtype = t;
        it.mcode = c;
        it.fok   = ok;
        it.id    = id;
        it.seq   = seq;
        send_item(it);
    endtask

    task automatic poll_slot(input logic [3:0] idx);
        ping_item_t it;
        it     = random_item(OP_POLL);
        it.idx = idx;
        send_item(it);
    endtask

    task automatic tick_clock();
        send_item(random_item(OP_TICK));
    endtask

    // stops offering and waits for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (echo_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    function automatic int pick_used_slot();
        int n;
        int pick;
        n = 0;
        foreach (tbl_used[i])
        begin
            if (tbl_used[i])
            begin
                n++;
            end
        end
        if (n == 0)
        begin
            return -1;
        end
        pick = $urandom_range(0, n - 1);
        foreach (tbl_used[i])
        begin
            if (tbl_used[i])
            begin
                if (pick == 0)
                begin
                    return i;
                end
                pick--;
            end
        end
        return -1;
    endfunction

    function automatic logic [7:0] pick_tracked_type();
        case ($urandom_range(0, 4))
            0:       return TYPE_ECHO_REPLY;
            1:       return TYPE_UNREACH;
            2:       return TYPE_REDIRECT;
            3:       return TYPE_TIME_EXC;
            default: return TYPE_PARAM;
        endcase
    endfunction

    // poll of a free slot and a tick on a fresh table
    task automatic test_empty_table();
        poll_slot(4'd15);
        tick_clock();
        drain_results();
    endtask

    // filtering of incoming messages, answer overwrite and finished polls
    task automatic test_message_filter();
        start_ping(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        start_ping(16'h0000, 16'hFFFF, 32'd0);
        start_ping(16'h1234, 16'h5678, 32'd2);
        poll_slot(4'd0);
        tick_clock();
        // echo reply with a nonzero code, stored with code zero
        send_msg(TYPE_ECHO_REPLY, 8'hFF, 1'b1, 16'hFFFF, 16'h0000);
        // bad frame, untracked type and wrong sequence all leave the table alone
        send_msg(TYPE_ECHO_REPLY, 8'h00, 1'b0, 16'h0000, 16'hFFFF);
        send_msg(8'd8, 8'h00, 1'b1, 16'h1234, 16'h5678);
        send_msg(TYPE_UNREACH, ADMIN_CODE, 1'b1, 16'h1234, 16'h5679);
        send_msg(TYPE_TIME_EXC, 8'h00, 1'b1, 16'h1234, 16'h5678);
        send_msg(TYPE_UNREACH, ADMIN_CODE, 1'b1, 16'h1234, 16'h5678);
        // answer to a slot whose timeout has already run out
        send_msg(TYPE_PARAM, 8'hFF, 1'b1, 16'h0000, 16'hFFFF);
        poll_slot(4'd0);
        poll_slot(4'd1);
        poll_slot(4'd2);
        poll_slot(4'd2);
        drain_results();
    endtask

    // pending until the limit, then timeout, then a late answer finds nothing
    task automatic test_timeouts();
        start_ping(16'h0000, 16'h0000, 32'd1);
        poll_slot(4'd0);
        tick_clock();
        poll_slot(4'd0);
        send_msg(TYPE_REDIRECT, 8'h01, 1'b1, 16'h0000, 16'h0000);
        drain_results();
    endtask

    // receiver holds off while starts keep coming: the block must stall its input,
    // and the table overflows on the last start
    task automatic test_backpressure_fill();
        gaps_on     = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        for (int i = 0; i <= TRACKER_SLOTS; i++)
        begin
            start_ping(16'($urandom), 16'($urandom), $urandom_range(0, 3));
        end
        tick_clock();
        for (int i = 0; i < TRACKER_SLOTS; i++)
        begin
            poll_slot(i[3:0]);
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    // mostly well-formed ping lifecycles with random content, plus noise
    task automatic test_random_traffic(input int count, input bit with_gaps);
        ping_item_t it;
        int         pick;
        int         s;
        gaps_on = with_gaps;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                it = random_item(OP_START);
                // small key pool so duplicate keys share the table
                if ($urandom_range(0, 3) == 0)
                begin
                    it.id  = 16'($urandom_range(0, 3));
                    it.seq = 16'($urandom_range(0, 3));
                end
                case ($urandom_range(0, 9))
                    0:       it.lim = $urandom;
                    1:       it.lim = 32'hFFFF_FFFF;
                    default: it.lim = $urandom_range(0, 12);
                endcase
            end
            else if (pick < 55)
            begin
                it = random_item(OP_MSG);
                s  = pick_used_slot();
                if (s >= 0 && $urandom_range(0, 3) != 0)
                begin
                    it.id    = tbl_id[s];
                    it.seq   = tbl_seq[s];
                    it.fok   = ($urandom_range(0, 9) != 0);
                    it.mtype = pick_tracked_type();
                    if ($urandom_range(0, 9) < 7)
                    begin
                        it.mcode = ($urandom_range(0, 7) == 0) ? ADMIN_CODE :
                                   8'($urandom_range(0, 6));
                    end
                end
            end
            else if (pick < 85)
            begin
                it = random_item(OP_POLL);
                s  = pick_used_slot();
                if (s >= 0 && $urandom_range(0, 4) != 0)
                begin
                    it.idx = s[3:0];
                end
            end
            else
            begin
                it = random_item(OP_TICK);
            end
            send_item(it);
        end
        drain_results();
    endtask

    // receiver: long hold-off on request, otherwise random stalls when gaps are on
    always @(posedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_left     = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_left > 0)
        begin
            out_stall <= 1'b1;
            rx_left--;
        end
        else if (!gaps_on)
        begin
            out_stall <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            out_stall <= 1'b1;
            rx_gap--;
        end
        else
        begin
            out_stall <= 1'b0;
            rx_gap = pick_gap();
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // each result transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        echo_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (echo_results_q.size() == 0)
            begin
                $error("result transfer with nothing expected, result_kind %0d", result_kind);
                fail_count++;
            end
            else
            begin
                want = echo_results_q.pop_front();
                kind_count[want.kind]++;
                compare_field("result_kind", 32'(want.kind), 32'(result_kind));
                compare_field("slot_out", 32'(want.slot), 32'(slot_out));
                compare_field("ping_status", 32'(want.status), 32'(ping_status));
                compare_field("rtt_ms", want.rtt, rtt_ms);
                compare_field("reply_type", 32'(want.rtype), 32'(reply_type));
                compare_field("reply_code", 32'(want.rcode), 32'(reply_code));
                compare_field("success", 32'(want.ok), 32'(success));
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_message_filter();
        test_timeouts();
        test_backpressure_fill();
        test_random_traffic(200, 1'b1);
        test_random_traffic(200, 1'b0);
        test_random_traffic(200, 1'b1);
        // anything arriving now is unexpected and flagged by the checker
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d transfers in %0d cycles, clock reached %0d ms",
                 items_sent, cycle_count, clock_ms);
        $display("started %0d, full %0d, pending %0d, finished %0d, matched %0d, %s %0d, ticks %0d",
                 kind_count[RK_STARTED], kind_count[RK_FULL], kind_count[RK_PENDING],
                 kind_count[RK_FINISHED], kind_count[RK_MATCHED], "ignored",
                 kind_count[RK_IGNORED], kind_count[RK_TICK]);
        if (fail_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
